/* rtl/core/frp_pkg.sv */
// Shared types and constants for the FTP reply parser.
`timescale 1ns / 1ps
package frp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned LIMIT_W     = 16;

	// result kinds
	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error causes
	localparam logic [2:0] CAUSE_NONE    = 3'd0;
	localparam logic [2:0] CAUSE_SEP     = 3'd1;
	localparam logic [2:0] CAUSE_DIGIT   = 3'd2;
	localparam logic [2:0] CAUSE_TOOLONG = 3'd3;
	localparam logic [2:0] CAUSE_EOS     = 3'd4;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4094;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [9:0] reply_code;
		logic [2:0] error_cause;
		logic       last;
	} out_item_t;

	// one result without its last flag
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [9:0] reply_code;
		logic [2:0] error_cause;
	} res_t;

	// work for the back end: an optional held CR, then an optional main result
	typedef struct packed {
		logic pre_cr;
		logic main_valid;
		res_t main;
	} work_t;

endpackage

/* rtl/core/frp_front.sv */
// Front end: byte classifier and line state machine of the reply parser.
`timescale 1ns / 1ps
module frp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  frp_pkg::in_item_t            item,
	input  logic [frp_pkg::LIMIT_W-1:0]  text_limit,
	output logic                         work_valid,
	output frp_pkg::work_t               work
);

	typedef enum logic [1:0] {
		PH_TAG  = 2'd0,
		PH_SKIP = 2'd1,
		PH_TEXT = 2'd2
	} phase_t;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	phase_t                      phase_q, phase_d;
	logic [1:0]                  tag_pos_q, tag_pos_d;
	logic [7:0]                  tag_q [3];
	logic                        tag_wr;
	logic [frp_pkg::LIMIT_W-1:0] count_q, count_d;
	logic                        cr_q, cr_d;
	logic                        digits_ok;
	logic [9:0]                  code;
	frp_pkg::work_t              w;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic [9:0] digit_val(input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return {6'd0, d[3:0]};
	endfunction

	assign digits_ok = is_digit(tag_q[0]) && is_digit(tag_q[1]) && is_digit(tag_q[2]);
	assign code = digit_val(tag_q[0]) * 10'd100 + digit_val(tag_q[1]) * 10'd10
		+ digit_val(tag_q[2]);

	always_comb begin
		phase_d   = phase_q;
		tag_pos_d = tag_pos_q;
		count_d   = count_q;
		cr_d      = cr_q;
		tag_wr    = 1'b0;
		w         = '0;
		if (item.stream_end) begin
			w.main_valid       = 1'b1;
			w.main.kind        = frp_pkg::KIND_ERR;
			w.main.error_cause = frp_pkg::CAUSE_EOS;
			phase_d = PH_TAG; tag_pos_d = '0; count_d = '0; cr_d = 1'b0;
		end else begin
			case (phase_q)
				PH_SKIP: begin
					if (item.rx_byte == frp_pkg::CH_LF) begin
						phase_d = PH_TAG; tag_pos_d = '0; count_d = '0; cr_d = 1'b0;
					end
				end
				PH_TEXT: begin
					if (item.rx_byte == frp_pkg::CH_LF) begin
						w.main_valid = 1'b1;
						if (digits_ok) begin
							w.main.kind       = frp_pkg::KIND_DONE;
							w.main.reply_code = code;
						end else begin
							w.main.kind        = frp_pkg::KIND_ERR;
							w.main.error_cause = frp_pkg::CAUSE_DIGIT;
						end
						phase_d = PH_TAG; tag_pos_d = '0; count_d = '0; cr_d = 1'b0;
					end else begin
						// a held CR goes out ahead of whatever this byte gives
						w.pre_cr = cr_q;
						cr_d     = 1'b0;
						if (count_q >= text_limit) begin
							w.main_valid       = 1'b1;
							w.main.kind        = frp_pkg::KIND_ERR;
							w.main.error_cause = frp_pkg::CAUSE_TOOLONG;
							phase_d = PH_TAG; tag_pos_d = '0; count_d = '0;
						end else begin
							count_d = count_q + 1'b1;
							if (item.rx_byte == frp_pkg::CH_CR) begin
								cr_d = 1'b1;
							end else begin
								w.main_valid     = 1'b1;
								w.main.kind      = frp_pkg::KIND_TEXT;
								w.main.data_byte = item.rx_byte;
							end
						end
					end
				end
				default: begin
					if (tag_pos_q != 2'd3) begin
						tag_wr    = 1'b1;
						tag_pos_d = tag_pos_q + 1'b1;
					end else if (item.rx_byte == CH_DASH) begin
						phase_d   = PH_SKIP;
						tag_pos_d = '0;
					end else if (item.rx_byte == CH_SPACE) begin
						phase_d   = PH_TEXT;
						tag_pos_d = '0;
						count_d   = '0;
						cr_d      = 1'b0;
					end else begin
						w.main_valid       = 1'b1;
						w.main.kind        = frp_pkg::KIND_ERR;
						w.main.error_cause = frp_pkg::CAUSE_SEP;
						phase_d = PH_TAG; tag_pos_d = '0; count_d = '0; cr_d = 1'b0;
					end
				end
			endcase
		end
	end

	assign work       = w;
	assign work_valid = take && (w.pre_cr || w.main_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			tag_pos_q <= '0;
			count_q   <= '0;
			cr_q      <= 1'b0;
			tag_q[0]  <= '0;
			tag_q[1]  <= '0;
			tag_q[2]  <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			tag_pos_q <= tag_pos_d;
			count_q   <= count_d;
			cr_q      <= cr_d;
			if (tag_wr) begin
				tag_q[tag_pos_q] <= item.rx_byte;
			end
		end
	end

endmodule

/* rtl/core/frp_queue.sv */
// Small work queue between the front and back ends.
`timescale 1ns / 1ps
module frp_queue #(
	parameter int unsigned DEPTH = frp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  frp_pkg::work_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output frp_pkg::work_t rd_data,
	output logic           empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	frp_pkg::work_t mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/frp_back.sv */
// Back end: expands queued work into result transfers through an output register.
`timescale 1ns / 1ps
module frp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  frp_pkg::work_t     q_data,
	output logic               q_pop,
	output frp_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	frp_pkg::out_item_t out_q;
	logic               valid_q;
	logic               pend_q;   // main result still owed after a CR
	frp_pkg::res_t      held_q;
	logic               load;

	assign load   = !valid_q || pop;
	assign q_pop  = load && !pend_q && !q_empty;
	assign result = out_q;
	assign empty  = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				pend_q  <= q_data.pre_cr && q_data.main_valid;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q <= {held_q, 1'b1};
			end else if (!q_empty) begin
				held_q <= q_data.main;
				if (q_data.pre_cr) begin
					out_q.kind        <= frp_pkg::KIND_TEXT;
					out_q.data_byte   <= frp_pkg::CH_CR;
					out_q.reply_code  <= '0;
					out_q.error_cause <= frp_pkg::CAUSE_NONE;
					out_q.last        <= !q_data.main_valid;
				end else begin
					out_q <= {q_data.main, 1'b1};
				end
			end
		end
	end

endmodule

/* rtl/core/ftp_reply_parser.sv */
// Top level of the FTP control-channel reply parser.
`timescale 1ns / 1ps
// Takes one received byte per cycle while full is low and gives text bytes of
// the final reply line, the decimal reply code, or an error cause. Each byte
// is classified by the front end; any results it causes go into a work queue
// of QUEUE_DEPTH entries and are drained by the back end at one result per
// cycle while pop is held. A byte following a held carriage return may cause
// two results, sent one after the other; full rises only when the queue has
// filled behind such pairs or a stalled pop. text_limit sits at byte address 0.
module ftp_reply_parser #(
	parameter int unsigned QUEUE_DEPTH = frp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  frp_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output frp_pkg::out_item_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [frp_pkg::LIMIT_W-1:0] limit_q;
	logic                        take;
	logic                        work_valid;
	frp_pkg::work_t              work;
	logic                        q_full, q_empty, q_pop;
	frp_pkg::work_t              q_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= frp_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			limit_q <= pwdata[15:0];
		end
	end

	assign full = q_full;
	assign take = push && !q_full;

	frp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item),
		.text_limit (limit_q),
		.work_valid (work_valid),
		.work       (work)
	);

	frp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (work_valid),
		.wr_data (work),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	frp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	// completions and errors always close out their byte
	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind != frp_pkg::KIND_TEXT |-> result.last)
		else $error("reply end or error without last");

	// the second result of a pair follows right behind the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !result.last |=> !empty)
		else $error("second result of a pair missing");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind == frp_pkg::KIND_DONE |->
		result.reply_code <= 10'd999 && result.error_cause == frp_pkg::CAUSE_NONE)
		else $error("bad reply code transfer");

endmodule
